// ===== hdl/rgb16_brightness_contrast_macros.svh =====
// ----------------------------------------------------------------------------
// RGB16 brightness/contrast assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef RGB16_BRIGHTNESS_CONTRAST_MACROS_SVH
`define RGB16_BRIGHTNESS_CONTRAST_MACROS_SVH

// same-cycle implication
`define RGBBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rgbbc_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB16 brightness/contrast package
// Widths, constants and shared types of the pixel adjust pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbbc_pkg;

  localparam int unsigned PixW      = 16;
  localparam int unsigned BrightW   = 8;
  localparam int unsigned GainW     = 8;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned NumCh     = 3;
  localparam int unsigned ProdW     = PixW + GainW;
  localparam int unsigned OffW      = BrightW + PixW;
  localparam int unsigned SumW      = 31;
  localparam int unsigned SumExtW   = SumW + 1;
  localparam int unsigned NumW      = SumW + PixW;
  localparam int unsigned PreStages = 4;
  localparam int unsigned DivSteps  = PixW;
  localparam int unsigned PipeDepth = PreStages + DivSteps;

  localparam logic [PixW-1:0]    FullScale     = '1;
  localparam logic [SumW-1:0]    FullScaleX100 = SumW'(6553500);
  localparam logic [SumExtW-1:0] Pct           = SumExtW'(100);
  localparam logic [BrightW-1:0] BrightReset   = BrightW'(100);
  localparam logic [GainW-1:0]   GainReset     = GainW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgBrightness = 1'b0,
    CfgContrast   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [BrightW-1:0] brightness;
    logic [GainW-1:0]   gain;
  } cfg_t;

  // divider stage payload; channel 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [SumW-1:0]                d;
    logic [NumCh-1:0][SumW-1:0]     rem;
    logic [NumCh-1:0][PixW-1:0]     lo;
    logic [NumCh-1:0][PixW-1:0]     q;
    logic [PixW-1:0]                alpha;
  } div_pl_t;

endpackage

`default_nettype wire

// ===== hdl/rgbbc_if.sv =====
// ----------------------------------------------------------------------------
// RGB16 brightness/contrast pixel channels
// Valid/ready request channels for source and adjusted pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rgbbc_in_if;
  logic                       valid;
  logic                       ready;
  logic [rgbbc_pkg::PixW-1:0] red_in;
  logic [rgbbc_pkg::PixW-1:0] green_in;
  logic [rgbbc_pkg::PixW-1:0] blue_in;
  logic [rgbbc_pkg::PixW-1:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rgbbc_out_if;
  logic                       valid;
  logic                       ready;
  logic [rgbbc_pkg::PixW-1:0] red_out;
  logic [rgbbc_pkg::PixW-1:0] green_out;
  logic [rgbbc_pkg::PixW-1:0] blue_out;
  logic [rgbbc_pkg::PixW-1:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/rgbbc_pre.sv =====
// ----------------------------------------------------------------------------
// RGB16 brightness/contrast front end
// Gain, offset and clamp, channel maximum, divisor and dividend setup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbbc_pre (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic [rgbbc_pkg::PreStages-1:0]           en_i,
  input  wire logic                                      valid_i,
  input  wire logic [rgbbc_pkg::PixW-1:0]                red_i,
  input  wire logic [rgbbc_pkg::PixW-1:0]                green_i,
  input  wire logic [rgbbc_pkg::PixW-1:0]                blue_i,
  input  wire logic [rgbbc_pkg::PixW-1:0]                alpha_i,
  input  wire rgbbc_pkg::cfg_t                           cfg_i,
  output      logic [rgbbc_pkg::PreStages-1:0]           valid_o,
  output      rgbbc_pkg::div_pl_t                        pl_o
);

  logic [rgbbc_pkg::PreStages-1:0] v_q, v_d;

  logic [rgbbc_pkg::NumCh-1:0][rgbbc_pkg::PixW-1:0]  chan_in;
  logic [rgbbc_pkg::NumCh-1:0][rgbbc_pkg::ProdW-1:0] prod_q, prod_d;
  logic [rgbbc_pkg::OffW-1:0]                        boff_q, boff_d;
  logic [rgbbc_pkg::NumCh-1:0][rgbbc_pkg::SumW-1:0]  s1_q, s1_d;
  logic [rgbbc_pkg::NumCh-1:0][rgbbc_pkg::SumW-1:0]  s2_q;
  logic [rgbbc_pkg::SumW-1:0]                        m_q, m_d;
  logic [rgbbc_pkg::PixW-1:0]                        a0_q, a1_q, a2_q;
  rgbbc_pkg::div_pl_t                                pl_q, pl_d;

  assign chan_in = {blue_i, green_i, red_i};

  // stage 0: channel gain and brightness offset
  always_comb begin
    for (int i = 0; i < rgbbc_pkg::NumCh; i++) begin
      prod_d[i] = rgbbc_pkg::ProdW'(chan_in[i]) * rgbbc_pkg::ProdW'(cfg_i.gain);
    end
    boff_d = rgbbc_pkg::OffW'(cfg_i.brightness) * rgbbc_pkg::OffW'(rgbbc_pkg::FullScale);
  end

  // stage 1: sum in units of 1/100, clamp at zero
  always_comb begin
    logic [rgbbc_pkg::SumExtW-1:0] t;
    for (int i = 0; i < rgbbc_pkg::NumCh; i++) begin
      t = rgbbc_pkg::SumExtW'(prod_q[i]) * rgbbc_pkg::Pct + rgbbc_pkg::SumExtW'(boff_q);
      if (t > rgbbc_pkg::SumExtW'(rgbbc_pkg::FullScaleX100)) begin
        s1_d[i] = rgbbc_pkg::SumW'(t - rgbbc_pkg::SumExtW'(rgbbc_pkg::FullScaleX100));
      end else begin
        s1_d[i] = '0;
      end
    end
  end

  // stage 2: largest channel
  always_comb begin
    m_d = s1_q[0];
    if (s1_q[1] > m_d) begin
      m_d = s1_q[1];
    end
    if (s1_q[2] > m_d) begin
      m_d = s1_q[2];
    end
  end

  // stage 3: divisor is max(m, full scale); dividend is s * 65535
  always_comb begin
    logic [rgbbc_pkg::NumW-1:0] num;
    pl_d.d = (m_q > rgbbc_pkg::FullScaleX100) ? m_q : rgbbc_pkg::FullScaleX100;
    for (int i = 0; i < rgbbc_pkg::NumCh; i++) begin
      num = (rgbbc_pkg::NumW'(s2_q[i]) << rgbbc_pkg::PixW) - rgbbc_pkg::NumW'(s2_q[i]);
      pl_d.rem[i] = num[rgbbc_pkg::NumW-1:rgbbc_pkg::PixW];
      pl_d.lo[i]  = num[rgbbc_pkg::PixW-1:0];
      pl_d.q[i]   = '0;
    end
    pl_d.alpha = a2_q;
  end

  always_comb begin
    v_d = {v_q[rgbbc_pkg::PreStages-2:0], valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < rgbbc_pkg::PreStages; k++) begin
        if (en_i[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      boff_q <= boff_d;
      a0_q   <= alpha_i;
    end
    if (en_i[1]) begin
      s1_q <= s1_d;
      a1_q <= a0_q;
    end
    if (en_i[2]) begin
      s2_q <= s1_q;
      m_q  <= m_d;
      a2_q <= a1_q;
    end
    if (en_i[3]) begin
      pl_q <= pl_d;
    end
  end

  assign valid_o = v_q;
  assign pl_o    = pl_q;

endmodule

`default_nettype wire

// ===== hdl/rgbbc_div_step.sv =====
// ----------------------------------------------------------------------------
// RGB16 brightness/contrast divider step
// One restoring division step per channel: one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbbc_div_step (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire rgbbc_pkg::div_pl_t pl_i,
  output      logic               valid_o,
  output      rgbbc_pkg::div_pl_t pl_o
);

  logic               v_q;
  rgbbc_pkg::div_pl_t pl_q, pl_d;

  always_comb begin
    logic [rgbbc_pkg::SumExtW-1:0] sh;
    logic [rgbbc_pkg::SumExtW-1:0] dx;
    logic                          ge;
    dx = rgbbc_pkg::SumExtW'(pl_i.d);
    pl_d = pl_i;
    for (int i = 0; i < rgbbc_pkg::NumCh; i++) begin
      sh = {pl_i.rem[i], pl_i.lo[i][rgbbc_pkg::PixW-1]};
      ge = (sh >= dx);
      // partial remainder stays below the divisor
      pl_d.rem[i] = ge ? rgbbc_pkg::SumW'(sh - dx) : rgbbc_pkg::SumW'(sh);
      pl_d.lo[i]  = {pl_i.lo[i][rgbbc_pkg::PixW-2:0], 1'b0};
      pl_d.q[i]   = {pl_i.q[i][rgbbc_pkg::PixW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= pl_d;
    end
  end

  assign valid_o = v_q;
  assign pl_o    = pl_q;

endmodule

`default_nettype wire

// ===== hdl/rgb16_brightness_contrast.sv =====
// ----------------------------------------------------------------------------
// RGB16 brightness/contrast adjust
// 16-bit RGBA pixel gain, offset, clamp and hue-keeping rescale.
// ----------------------------------------------------------------------------
// Takes one pixel per clock when the output is not held off. The pipeline has
// four setup stages (gain, offset and clamp, channel max, dividend) followed
// by a 16-stage restoring divider that resolves one quotient bit per stage for
// all three channels at once. Every stage has its own valid bit and holds only
// while it and every stage after it are full and the output is stalled, so
// bubbles close up and input is taken while a result waits. Alpha is carried
// along unchanged. Configuration writes are registered and must be made while
// no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rgb16_brightness_contrast (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rgbbc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [rgbbc_pkg::CfgDataW-1:0]      cfg_data_i,
  rgbbc_in_if.sink                                 pix_i,
  rgbbc_out_if.source                              pix_o
);

  localparam int unsigned Depth = rgbbc_pkg::PipeDepth;

  rgbbc_pkg::cfg_t                  cfg_q;
  logic [Depth-1:0]                 v;
  logic [Depth-1:0]                 en;
  logic [rgbbc_pkg::PreStages-1:0]  v_pre;
  logic [rgbbc_pkg::DivSteps:0]     v_div;
  rgbbc_pkg::div_pl_t               pl_s [rgbbc_pkg::DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness <= rgbbc_pkg::BrightReset;
      cfg_q.gain       <= rgbbc_pkg::GainReset;
    end else if (cfg_we_i) begin
      unique case (rgbbc_pkg::cfg_reg_e'(cfg_idx_i))
        rgbbc_pkg::CfgBrightness: cfg_q.brightness <= cfg_data_i;
        rgbbc_pkg::CfgContrast:   cfg_q.gain       <= cfg_data_i;
      endcase
    end
  end

  assign v = {v_div[rgbbc_pkg::DivSteps:1], v_pre};

  // a stage may load when it is empty or some stage downstream can move
  always_comb begin
    logic [Depth-1:0] mask;
    for (int k = 0; k < Depth; k++) begin
      mask  = {Depth{1'b1}} << k;
      en[k] = pix_o.ready || ((v & mask) != mask);
    end
  end

  rgbbc_pre u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[rgbbc_pkg::PreStages-1:0]),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red_in),
    .green_i (pix_i.green_in),
    .blue_i  (pix_i.blue_in),
    .alpha_i (pix_i.alpha_in),
    .cfg_i   (cfg_q),
    .valid_o (v_pre),
    .pl_o    (pl_s[0])
  );

  assign v_div[0] = v_pre[rgbbc_pkg::PreStages-1];

  for (genvar g = 0; g < rgbbc_pkg::DivSteps; g++) begin : g_div
    rgbbc_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[rgbbc_pkg::PreStages+g]),
      .valid_i (v_div[g]),
      .pl_i    (pl_s[g]),
      .valid_o (v_div[g+1]),
      .pl_o    (pl_s[g+1])
    );
  end

  assign pix_i.ready     = en[0];
  assign pix_o.valid     = v_div[rgbbc_pkg::DivSteps];
  assign pix_o.red_out   = pl_s[rgbbc_pkg::DivSteps].q[0];
  assign pix_o.green_out = pl_s[rgbbc_pkg::DivSteps].q[1];
  assign pix_o.blue_out  = pl_s[rgbbc_pkg::DivSteps].q[2];
  assign pix_o.alpha_out = pl_s[rgbbc_pkg::DivSteps].alpha;

endmodule

`default_nettype wire

// ===== hdl/rgbbc_chk.sv =====
// ----------------------------------------------------------------------------
// RGB16 brightness/contrast port checker
// Watches the pixel channels for occupancy and flow-control slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb16_brightness_contrast_macros.svh"

module rgbbc_chk (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic [rgbbc_pkg::PixW-1:0] red_i,
  input  wire logic [rgbbc_pkg::PixW-1:0] green_i,
  input  wire logic [rgbbc_pkg::PixW-1:0] blue_i,
  input  wire logic [rgbbc_pkg::PixW-1:0] alpha_i
);

  localparam int unsigned CntW = $clog2(rgbbc_pkg::PipeDepth + 1) + 1;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            acc_in, acc_out;

  assign acc_in  = in_valid_i && in_ready_i;
  assign acc_out = out_valid_i && out_ready_i;

  // requests in flight
  always_comb begin
    cnt_d = cnt_q + CntW'(acc_in) - CntW'(acc_out);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `RGBBC_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(red_i) && $stable(green_i) && $stable(blue_i) && $stable(alpha_i), "stalled result changed")
  `RGBBC_ASSERT_IMP(a_idle_ready, !out_valid_i, in_ready_i, "input held off with no result waiting")
  `RGBBC_ASSERT_IMP(a_no_phantom, out_valid_i, cnt_q != '0, "result without an outstanding request")
  `RGBBC_ASSERT_IMP(a_capacity, 1'b1, cnt_q <= CntW'(rgbbc_pkg::PipeDepth), "more requests in flight than stages")

endmodule

bind rgb16_brightness_contrast rgbbc_chk u_rgbbc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .red_i       (pix_o.red_out),
  .green_i     (pix_o.green_out),
  .blue_i      (pix_o.blue_out),
  .alpha_i     (pix_o.alpha_out)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB16 brightness/contrast adjust testbench
// Drives RGBA pixels through the adjust pipeline under several brightness and
// gain settings, predicts each adjusted pixel in integer math and compares it
// field by field, with random source gaps, sink stalls and one long hold-off.
// ----------------------------------------------------------------------------

module tb;
  import rgbbc_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic [PixW-1:0] alpha;
  } pixel_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgBrightness;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  rgbbc_in_if  pix_in ();
  rgbbc_out_if pix_out ();

  rgb16_brightness_contrast dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_in),
    .pix_o      (pix_out)
  );

  logic [BrightW-1:0] cur_brightness = BrightReset;
  logic [GainW-1:0]   cur_gain = GainReset;
  pixel_t             pending_px[$];
  int                 err_cnt = 0;
  bit                 src_gaps = 1'b1;
  bit                 sink_stalls = 1'b1;
  int                 hold_len = 0;

  always #1 clk_i = ~clk_i;

  initial begin
    pix_in.valid    = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_in.alpha_in = '0;
    pix_out.ready   = 1'b0;
  end

  // ---- predictor ----
  function automatic longint offset_chan(input logic [PixW-1:0] c);
    longint s;
    s = 100 * longint'(c) * longint'(cur_gain)
      + longint'(FullScale) * longint'(cur_brightness) - longint'(FullScaleX100);
    return (s < 0) ? 0 : s;
  endfunction

  function automatic logic [PixW-1:0] fit_chan(input longint s, input longint peak);
    if (peak > longint'(FullScaleX100)) return PixW'((s * longint'(FullScale)) / peak);
    return PixW'(s / 100);
  endfunction

  function automatic pixel_t adjust_pixel(input pixel_t px);
    longint r, g, b, peak;
    pixel_t res;
    r = offset_chan(px.red);
    g = offset_chan(px.green);
    b = offset_chan(px.blue);
    peak = r;
    if (g > peak) peak = g;
    if (b > peak) peak = b;
    res.red   = fit_chan(r, peak);
    res.green = fit_chan(g, peak);
    res.blue  = fit_chan(b, peak);
    res.alpha = px.alpha;
    return res;
  endfunction

  // ---- result checking ----
  task automatic check_chan(input string name, input logic [PixW-1:0] want,
                            input logic [PixW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected pixel: expected none actual %h %h %h %h", $time,
                 pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.alpha_out);
        err_cnt++;
      end else begin
        want = pending_px.pop_front();
        check_chan("red",   want.red,   pix_out.red_out);
        check_chan("green", want.green, pix_out.green_out);
        check_chan("blue",  want.blue,  pix_out.blue_out);
        check_chan("alpha", want.alpha, pix_out.alpha_out);
      end
    end
  end

  // ---- sink side: random stalls plus requested long hold-off ----
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len = 0;
      end
      if (hold_left > 0) begin
        pix_out.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pix_out.ready = 1'b0;
        stall_left--;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        pix_out.ready = 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        pix_out.ready = 1'b1;
      end
    end
  end

  // ---- source side ----
  task automatic send_pixel(input pixel_t px);
    int gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      pix_in.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pix_in.valid    = 1'b1;
    pix_in.red_in   = px.red;
    pix_in.green_in = px.green;
    pix_in.blue_in  = px.blue;
    pix_in.alpha_in = px.alpha;
    do @(posedge clk_i); while (!pix_in.ready);
    pending_px.push_back(adjust_pixel(px));
  endtask

  task automatic send_rgba(input int r, input int g, input int b, input int a);
    send_pixel('{red: PixW'(r), green: PixW'(g), blue: PixW'(b), alpha: PixW'(a)});
  endtask

  task automatic drain;
    @(negedge clk_i);
    pix_in.valid = 1'b0;
    while (pending_px.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgBrightness: cur_brightness = val;
      CfgContrast:   cur_gain = val;
      default: ;
    endcase
  endtask

  task automatic set_levels(input int bright, input int gain);
    drain();
    write_reg(CfgBrightness, CfgDataW'(bright));
    write_reg(CfgContrast, CfgDataW'(gain));
  endtask

  function automatic logic [PixW-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return PixW'($urandom_range(0, 255));
      3: return PixW'($urandom_range(65280, 65535));
      default: return PixW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.red   = rand_chan();
    px.green = ($urandom_range(0, 7) == 0) ? px.red : rand_chan();
    px.blue  = ($urandom_range(0, 7) == 0) ? px.green : rand_chan();
    px.alpha = PixW'($urandom_range(0, 65535));
    return px;
  endfunction

  // ---- tests ----
  task automatic test_reset_levels;
    send_rgba(0, 0, 0, 0);
    send_rgba(65535, 65535, 65535, 65535);
    send_rgba(1, 32768, 65534, 16'h5a5a);
  endtask

  task automatic test_zero_gain;
    set_levels(0, 0);
    send_rgba(65535, 1234, 0, 7);
    set_levels(200, 0);
    send_rgba(0, 65535, 40000, 8);
    set_levels(255, 0);
    send_rgba(100, 200, 300, 9);
  endtask

  task automatic test_overflow_rescale;
    set_levels(100, 2);
    send_rgba(40000, 20000, 10000, 1);
    send_rgba(50000, 50000, 100, 2);
    send_rgba(30000, 30000, 30000, 3);
    set_levels(255, 255);
    send_rgba(0, 0, 0, 4);
    send_rgba(65535, 0, 1, 5);
    send_rgba(1, 2, 3, 6);
    set_levels(0, 255);
    send_rgba(257, 256, 300, 16'hffff);
    send_rgba(65535, 65535, 0, 16'h8000);
    set_levels(201, 1);
    send_rgba(0, 65535, 100, 16'h0001);
  endtask

  task automatic test_random_levels;
    int bright, gain;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin bright = 100; gain = 1;   end
        1: begin bright = 0;   gain = 0;   end
        2: begin bright = 200; gain = 255; end
        3: begin bright = 255; gain = 1;   end
        default: begin
          bright = $urandom_range(0, 255);
          gain = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        end
      endcase
      set_levels(bright, gain);
      repeat (140) send_pixel(rand_pixel());
    end
  endtask

  task automatic test_output_hold_off;
    set_levels($urandom_range(60, 140), $urandom_range(1, 2));
    src_gaps = 1'b0;
    hold_len = 80;
    repeat (60) send_pixel(rand_pixel());
    src_gaps = 1'b1;
  endtask

  task automatic test_full_rate;
    set_levels($urandom_range(80, 160), 1);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (120) send_pixel(rand_pixel());
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_levels();
    test_zero_gain();
    test_overflow_rescale();
    test_random_levels();
    test_output_hold_off();
    test_full_rate();
    drain();
    repeat (PipeDepth + 5) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
